/* rtl/mm_pkg.sv */
// shared types and codes for the integer matrix multiply block
// no dependencies; used by mm_seq, mm_mac and matrix_multiply

package mm_pkg;

	// element width of the stores and of the result
	localparam int ELEM_W = 32;
	// width of a row or column field on the ports
	localparam int POS_W  = 3;
	// width of a size register
	localparam int SIZE_W = 4;
	// width of a register index on the configuration port
	localparam int REG_IDX_W = 2;

	// function codes of an input item
	localparam logic [1:0] FUNC_LOAD_A = 2'd0;
	localparam logic [1:0] FUNC_LOAD_B = 2'd1;
	localparam logic [1:0] FUNC_MULT   = 2'd2;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_COLS_B    = 2'd2;

	typedef struct packed {
		logic [1:0]              func;
		logic [POS_W-1:0]        row_index;
		logic [POS_W-1:0]        col_index;
		logic signed [ELEM_W-1:0] elem_value;
	} in_item_t;

	typedef struct packed {
		logic [POS_W-1:0]        out_row;
		logic [POS_W-1:0]        out_col;
		logic signed [ELEM_W-1:0] out_value;
		logic                    last;
	} out_item_t;

	// one inner-dimension step handed from the sequencer to the datapath
	typedef struct packed {
		logic             valid;
		logic             first;
		logic             last_k;
		logic             last_elem;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} issue_t;

endpackage

/* rtl/mm_ram.sv */
// simple dual-port synchronous ram, one write and one registered read port
// no dependencies

module mm_ram #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6,
	parameter int WIDTH  = 32
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/mm_seq.sv */
// address sequencer: walks i, j and k for one multiply item
// depends on mm_pkg

module mm_seq #(
	parameter int MAX_DIM = 8,
	parameter int IDX_W   = 3,
	parameter int ADDR_W  = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                adv,
	input  logic [IDX_W-1:0]    m_last,
	input  logic [IDX_W-1:0]    n_last,
	input  logic [IDX_W-1:0]    p_last,
	output logic                active,
	output mm_pkg::issue_t      issue,
	output logic [ADDR_W-1:0]   a_addr,
	output logic [ADDR_W-1:0]   b_addr
);

	logic             active_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;
	logic [IDX_W-1:0] k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
		end else if (start) begin
			active_q <= 1'b1;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
		end else if (adv && active_q) begin
			if (k_q == n_last) begin
				k_q <= '0;
				if (j_q == p_last) begin
					j_q <= '0;
					if (i_q == m_last) begin
						active_q <= 1'b0;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end else begin
					j_q <= j_q + 1'b1;
				end
			end else begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	assign active = active_q;

	always_comb begin
		issue.valid     = active_q;
		issue.first     = (k_q == '0);
		issue.last_k    = (k_q == n_last);
		issue.last_elem = (k_q == n_last) && (j_q == p_last) && (i_q == m_last);
		issue.row       = mm_pkg::POS_W'(i_q);
		issue.col       = mm_pkg::POS_W'(j_q);
	end

	// a is row-major over i,k; b over k,j
	assign a_addr = ADDR_W'(int'(i_q) * MAX_DIM + int'(k_q));
	assign b_addr = ADDR_W'(int'(k_q) * MAX_DIM + int'(j_q));

endmodule

/* rtl/mm_mac.sv */
// multiply-accumulate datapath behind the two stores, with the output register
// depends on mm_pkg

module mm_mac (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  mm_pkg::issue_t              issue,
	input  logic [mm_pkg::ELEM_W-1:0]   a_data,
	input  logic [mm_pkg::ELEM_W-1:0]   b_data,
	output logic                        busy,
	output logic                        out_valid,
	output mm_pkg::out_item_t           out_item
);

	logic                      valid_s1;
	logic                      valid_s2;
	logic                      out_valid_q;
	mm_pkg::issue_t            tag_s1;
	mm_pkg::issue_t            tag_s2;
	logic [mm_pkg::ELEM_W-1:0] prod_s2;
	logic [mm_pkg::ELEM_W-1:0] acc_q;
	logic [mm_pkg::ELEM_W-1:0] sum;
	mm_pkg::out_item_t         out_q;

	// low half of the product is the same signed or unsigned
	assign sum = (tag_s2.first ? '0 : acc_q) + prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= issue.valid;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2 && tag_s2.last_k;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1  <= issue;
			tag_s2  <= tag_s1;
			prod_s2 <= mm_pkg::ELEM_W'(a_data * b_data);
			if (valid_s2) begin
				if (tag_s2.last_k) begin
					out_q.out_row   <= tag_s2.row;
					out_q.out_col   <= tag_s2.col;
					out_q.out_value <= sum;
					out_q.last      <= tag_s2.last_elem;
				end else begin
					acc_q <= sum;
				end
			end
		end
	end

	assign busy      = valid_s1 || valid_s2;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

/* rtl/matrix_multiply.sv */
// top level of the integer matrix multiply block, c = a x b
// depends on mm_pkg, mm_ram, mm_seq and mm_mac
//
// usage
//  - input channel (in_valid, in_stall, in_item): an item is taken at a clock
//    edge with in_valid high and in_stall low. func load a / load b writes one
//    element at row_index, col_index; loads outside the current sizes and the
//    unused function code are dropped. func multiply emits every element of c.
//  - output channel (out_valid, out_stall, out_item): one item per element of
//    c in row-major order, last set on the final one.
//  - cfg_write, cfg_index, cfg_data set rows_a, inner_dim, cols_b; write them
//    only while no multiply is in flight. a size of 0 acts as 1, above
//    MAX_DIM as MAX_DIM.
//  - rate: loads are taken one per cycle, back to back, while no multiply is
//    in flight. a multiply issues one product per cycle while the receiver
//    does not stall, set by the single read port of each store and the one
//    shared multiplier, behind the store read, product and output registers.
//  - in_stall is high from the cycle after a multiply is taken until its last
//    product has left the pipeline.
//  - when the receiver stalls with a result waiting, the whole read, multiply
//    and accumulate pipeline freezes; nothing is lost or repeated.
//  - reset clears the sizes to 1 and empties the pipeline; the stores are not
//    cleared, so every element used must be loaded first.

module matrix_multiply #(
	parameter int MAX_DIM = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  mm_pkg::in_item_t               in_item,
	output logic                           out_valid,
	input  logic                           out_stall,
	output mm_pkg::out_item_t              out_item,
	input  logic                           cfg_write,
	input  logic [mm_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [mm_pkg::SIZE_W-1:0]      cfg_data
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int ADDR_W = $clog2(DEPTH);

	// size register to last index, with clamping of out-of-range values
	function automatic logic [IDX_W-1:0] size_last(input logic [mm_pkg::SIZE_W-1:0] sz);
		logic [IDX_W-1:0] r;
		if (sz == '0) begin
			r = '0;
		end else if (int'(sz) > MAX_DIM) begin
			r = IDX_W'(MAX_DIM - 1);
		end else begin
			r = IDX_W'(sz - 1'b1);
		end
		return r;
	endfunction

	logic [mm_pkg::SIZE_W-1:0] rows_a_q;
	logic [mm_pkg::SIZE_W-1:0] inner_dim_q;
	logic [mm_pkg::SIZE_W-1:0] cols_b_q;

	logic [IDX_W-1:0] m_last;
	logic [IDX_W-1:0] n_last;
	logic [IDX_W-1:0] p_last;

	logic              in_accept;
	logic              start;
	logic              a_we;
	logic              b_we;
	logic [ADDR_W-1:0] load_addr;
	logic              adv;
	logic              seq_active;
	logic              mac_busy;
	mm_pkg::issue_t    issue;
	logic [ADDR_W-1:0] a_raddr;
	logic [ADDR_W-1:0] b_raddr;
	logic [mm_pkg::ELEM_W-1:0] a_rdata;
	logic [mm_pkg::ELEM_W-1:0] b_rdata;

	// size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= mm_pkg::SIZE_W'(1);
			inner_dim_q <= mm_pkg::SIZE_W'(1);
			cols_b_q    <= mm_pkg::SIZE_W'(1);
		end else if (cfg_write) begin
			unique case (cfg_index)
				mm_pkg::REG_ROWS_A:    rows_a_q    <= cfg_data;
				mm_pkg::REG_INNER_DIM: inner_dim_q <= cfg_data;
				mm_pkg::REG_COLS_B:    cols_b_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign m_last = size_last(rows_a_q);
	assign n_last = size_last(inner_dim_q);
	assign p_last = size_last(cols_b_q);

	// input decode; loads and multiplies are taken only while nothing is in flight
	assign in_stall  = seq_active || mac_busy;
	assign in_accept = in_valid && !in_stall;
	assign load_addr = ADDR_W'(int'(in_item.row_index) * MAX_DIM + int'(in_item.col_index));

	always_comb begin
		a_we  = 1'b0;
		b_we  = 1'b0;
		start = 1'b0;
		unique case (in_item.func)
			mm_pkg::FUNC_LOAD_A: begin
				a_we = in_accept && (in_item.row_index <= mm_pkg::POS_W'(m_last))
				       && (in_item.col_index <= mm_pkg::POS_W'(n_last));
			end
			mm_pkg::FUNC_LOAD_B: begin
				b_we = in_accept && (in_item.row_index <= mm_pkg::POS_W'(n_last))
				       && (in_item.col_index <= mm_pkg::POS_W'(p_last));
			end
			mm_pkg::FUNC_MULT: begin
				start = in_accept;
			end
			default: ;
		endcase
	end

	// pipeline moves whenever the output register is free or being taken
	assign adv = !out_valid || !out_stall;

	mm_ram #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W),
		.WIDTH  (mm_pkg::ELEM_W)
	) u_store_a (
		.clk   (clk),
		.we    (a_we),
		.waddr (load_addr),
		.wdata (in_item.elem_value),
		.re    (adv),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	mm_ram #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W),
		.WIDTH  (mm_pkg::ELEM_W)
	) u_store_b (
		.clk   (clk),
		.we    (b_we),
		.waddr (load_addr),
		.wdata (in_item.elem_value),
		.re    (adv),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	mm_seq #(
		.MAX_DIM (MAX_DIM),
		.IDX_W   (IDX_W),
		.ADDR_W  (ADDR_W)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.adv    (adv),
		.m_last (m_last),
		.n_last (n_last),
		.p_last (p_last),
		.active (seq_active),
		.issue  (issue),
		.a_addr (a_raddr),
		.b_addr (b_raddr)
	);

	mm_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.issue     (issue),
		.a_data    (a_rdata),
		.b_data    (b_rdata),
		.busy      (mac_busy),
		.out_valid (out_valid),
		.out_item  (out_item)
	);

	// stores are never written while a multiply is reading them
	assert property (@(posedge clk) disable iff (!arst_n)
		(a_we || b_we) |-> !(seq_active || mac_busy))
		else $error("store written during a multiply");

	// a taken multiply closes the input on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && in_item.func == mm_pkg::FUNC_MULT) |=> in_stall)
		else $error("input open right after a multiply was taken");

	// the sequencer stops right after it issues the final product
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && issue.valid && issue.last_elem) |=> !seq_active)
		else $error("sequencer still active after the final product");

endmodule

/* bench/tb_matrix_multiply.sv */
// self-checking bench for matrix_multiply: loads a and b, multiplies, checks every c element
// depends on mm_pkg and the matrix_multiply rtl; keeps its own copy of both stores
`timescale 1ns / 100ps

module tb_matrix_multiply;

	localparam int MAX_DIM      = 8;
	localparam int RAND_ITEMS   = 320;  // useful items in the random part
	localparam int IDLE_SETTLE  = 8;    // covers a load still in flight
	localparam int DRAIN_LIMIT  = 20000;
	localparam int END_SETTLE   = 30;
	localparam int TIMEOUT_NS   = 4000000;
	localparam int HOLD_CYCLES  = 200;

	// register index with no register behind it
	localparam logic [mm_pkg::REG_IDX_W-1:0] REG_UNUSED = 2'd3;
	// function code with no operation behind it
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	mm_pkg::in_item_t               in_item;
	logic                           out_valid;
	logic                           out_stall;
	mm_pkg::out_item_t              out_item;
	logic                           cfg_write;
	logic [mm_pkg::REG_IDX_W-1:0]   cfg_index;
	logic [mm_pkg::SIZE_W-1:0]      cfg_data;

	// bench copy of the block state
	logic signed [mm_pkg::ELEM_W-1:0] a_elem [MAX_DIM][MAX_DIM];
	logic signed [mm_pkg::ELEM_W-1:0] b_elem [MAX_DIM][MAX_DIM];
	bit                               a_set  [MAX_DIM][MAX_DIM];
	bit                               b_set  [MAX_DIM][MAX_DIM];
	logic [mm_pkg::SIZE_W-1:0]        rows_reg  = 4'd1;
	logic [mm_pkg::SIZE_W-1:0]        inner_reg = 4'd1;
	logic [mm_pkg::SIZE_W-1:0]        cols_reg  = 4'd1;

	// c elements still owed by the block, oldest first
	mm_pkg::out_item_t c_due [$];

	int error_count   = 0;
	int useful_items  = 0;   // in-range loads and multiplies taken
	int burst_left    = 0;
	int hold_request  = 0;   // long receiver hold-off, picked up by the stall process

	matrix_multiply u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// hard stop in case the block hangs
	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("** matrix_multiply: FAILED **");
		$finish;
	end

	function automatic void note_error(input string msg);
		error_count++;
		if (error_count <= 10) begin
			$display("%s", msg);
		end
	endfunction

	// 0 acts as 1, anything past the array size acts as the array size
	function automatic int eff_size(input logic [mm_pkg::SIZE_W-1:0] r);
		if (r == 0) return 1;
		if (r > MAX_DIM) return MAX_DIM;
		return int'(r);
	endfunction

	// c = a x b over the current sizes, row-major, sums wrap at the element width
	function automatic void queue_product(input int m, input int n, input int p);
		logic [mm_pkg::ELEM_W-1:0] acc;
		mm_pkg::out_item_t         elem;
		for (int i = 0; i < m; i++) begin
			for (int j = 0; j < p; j++) begin
				acc = '0;
				for (int k = 0; k < n; k++) begin
					acc = acc + a_elem[i][k] * b_elem[k][j];
				end
				elem.out_row   = mm_pkg::POS_W'(i);
				elem.out_col   = mm_pkg::POS_W'(j);
				elem.out_value = acc;
				elem.last      = (i == m - 1) && (j == p - 1);
				c_due.push_back(elem);
			end
		end
	endfunction

	// bench view of one item taken by the block
	function automatic void apply_item(input mm_pkg::in_item_t it);
		int m, n, p;
		m = eff_size(rows_reg);
		n = eff_size(inner_reg);
		p = eff_size(cols_reg);
		case (it.func)
			mm_pkg::FUNC_LOAD_A: begin
				// dropped when outside rows_a x inner_dim
				if (it.row_index < m && it.col_index < n) begin
					a_elem[it.row_index][it.col_index] = it.elem_value;
					a_set[it.row_index][it.col_index]  = 1'b1;
					useful_items++;
				end
			end
			mm_pkg::FUNC_LOAD_B: begin
				// dropped when outside inner_dim x cols_b
				if (it.row_index < n && it.col_index < p) begin
					b_elem[it.row_index][it.col_index] = it.elem_value;
					b_set[it.row_index][it.col_index]  = 1'b1;
					useful_items++;
				end
			end
			mm_pkg::FUNC_MULT: begin
				queue_product(m, n, p);
				useful_items++;
			end
			default: ;  // unused code, nothing happens
		endcase
	endfunction

	// result checker: every taken output item against the oldest owed element
	always @(posedge clk) begin : result_check
		mm_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (c_due.size() == 0) begin
				note_error($sformatf("unexpected result: row %0d col %0d value %0d last %0b",
					out_item.out_row, out_item.out_col, out_item.out_value, out_item.last));
			end else begin
				want = c_due.pop_front();
				if (out_item.out_row !== want.out_row || out_item.out_col !== want.out_col ||
				    out_item.out_value !== want.out_value || out_item.last !== want.last) begin
					note_error($sformatf({"result mismatch: expected row %0d col %0d value %0d ",
						"last %0b, got row %0d col %0d value %0d last %0b"},
						want.out_row, want.out_col, want.out_value, want.last,
						out_item.out_row, out_item.out_col, out_item.out_value,
						out_item.last));
				end
			end
		end
	end

	// receiver back-pressure: random modes, plus a long hold-off on request
	initial begin : receiver_stall
		stall_mode_t mode;
		int          mode_left;
		int          hold_left;
		out_stall = 1'b0;
		mode      = STALL_NONE;
		mode_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				if (mode_left == 0) begin
					mode      = stall_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 120);
				end
				mode_left--;
				case (mode)
					STALL_NONE:  out_stall <= 1'b0;
					STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 6);
					default:     out_stall <= ~out_stall;
				endcase
			end
		end
	end

	// mostly random words, with the extremes and small values mixed in
	function automatic logic signed [mm_pkg::ELEM_W-1:0] rand_elem();
		case ($urandom_range(0, 7))
			0:       return {1'b0, {(mm_pkg::ELEM_W-1){1'b1}}};
			1:       return {1'b1, {(mm_pkg::ELEM_W-1){1'b0}}};
			2, 3:    return mm_pkg::ELEM_W'(int'($urandom_range(0, 8)) - 4);
			default: return $urandom;
		endcase
	endfunction

	function automatic mm_pkg::in_item_t make_item(input logic [1:0] func, input int row,
	                                               input int col,
	                                               input logic signed [mm_pkg::ELEM_W-1:0] value);
		mm_pkg::in_item_t it;
		it.func       = func;
		it.row_index  = mm_pkg::POS_W'(row);
		it.col_index  = mm_pkg::POS_W'(col);
		it.elem_value = value;
		return it;
	endfunction

	// multiply item, the unused fields carry random bits
	function automatic mm_pkg::in_item_t mult_item();
		return make_item(mm_pkg::FUNC_MULT, $urandom_range(0, 7), $urandom_range(0, 7),
			$urandom);
	endfunction

	// offer one item and wait until the block takes it; sender runs in bursts
	task automatic push_item(input mm_pkg::in_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (in_stall);
		apply_item(it);
	endtask

	// drop valid and let every owed element arrive, then let a last load land
	task automatic wait_idle();
		in_valid  <= 1'b0;
		burst_left = 0;
		while (c_due.size() != 0) @(posedge clk);
		repeat (IDLE_SETTLE) @(posedge clk);
	endtask

	// one register write; cfg_write stays up for the next one
	task automatic write_reg(input logic [mm_pkg::REG_IDX_W-1:0] idx,
	                         input logic [mm_pkg::SIZE_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			mm_pkg::REG_ROWS_A:    rows_reg  = val;
			mm_pkg::REG_INNER_DIM: inner_reg = val;
			mm_pkg::REG_COLS_B:    cols_reg  = val;
			default: ;
		endcase
	endtask

	task automatic set_sizes(input logic [mm_pkg::SIZE_W-1:0] m,
	                         input logic [mm_pkg::SIZE_W-1:0] n,
	                         input logic [mm_pkg::SIZE_W-1:0] p);
		wait_idle();
		write_reg(mm_pkg::REG_ROWS_A, m);
		write_reg(mm_pkg::REG_INNER_DIM, n);
		write_reg(mm_pkg::REG_COLS_B, p);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// load every element the next multiply reads that was never loaded
	task automatic fill_missing();
		int m, n, p;
		m = eff_size(rows_reg);
		n = eff_size(inner_reg);
		p = eff_size(cols_reg);
		for (int i = 0; i < m; i++)
			for (int k = 0; k < n; k++)
				if (!a_set[i][k]) push_item(make_item(mm_pkg::FUNC_LOAD_A, i, k, rand_elem()));
		for (int k = 0; k < n; k++)
			for (int j = 0; j < p; j++)
				if (!b_set[k][j]) push_item(make_item(mm_pkg::FUNC_LOAD_B, k, j, rand_elem()));
	endtask

	// load somewhere inside the current sizes
	function automatic mm_pkg::in_item_t inside_load();
		int m, n, p;
		m = eff_size(rows_reg);
		n = eff_size(inner_reg);
		p = eff_size(cols_reg);
		if ($urandom_range(0, 1))
			return make_item(mm_pkg::FUNC_LOAD_A, $urandom_range(0, m - 1),
				$urandom_range(0, n - 1), rand_elem());
		return make_item(mm_pkg::FUNC_LOAD_B, $urandom_range(0, n - 1),
			$urandom_range(0, p - 1), rand_elem());
	endfunction

	// size values: mostly small, sometimes 0 or past the array size
	function automatic logic [mm_pkg::SIZE_W-1:0] pick_size();
		case ($urandom_range(0, 19))
			0:       return '0;
			1:       return mm_pkg::SIZE_W'($urandom_range(MAX_DIM + 1, 15));
			2, 3:    return mm_pkg::SIZE_W'($urandom_range(5, MAX_DIM));
			default: return mm_pkg::SIZE_W'($urandom_range(1, 4));
		endcase
	endfunction

	// ---------------------------------------------------------------- tests

	// reset sizes are 1x1x1; products that wrap
	task automatic test_reset_sizes();
		push_item(make_item(mm_pkg::FUNC_LOAD_A, 0, 0, {mm_pkg::ELEM_W{1'b1}}));
		push_item(make_item(mm_pkg::FUNC_LOAD_B, 0, 0,
			{1'b1, {(mm_pkg::ELEM_W-1){1'b0}}}));
		push_item(mult_item());
		push_item(make_item(mm_pkg::FUNC_LOAD_A, 0, 0,
			{1'b0, {(mm_pkg::ELEM_W-1){1'b1}}}));
		push_item(make_item(mm_pkg::FUNC_LOAD_B, 0, 0,
			{1'b0, {(mm_pkg::ELEM_W-1){1'b1}}}));
		push_item(mult_item());
	endtask

	// function code 3 must not touch either store
	task automatic test_unused_func();
		push_item(make_item(FUNC_UNUSED, 0, 0, 32'h1234_5678));
		push_item(make_item(FUNC_UNUSED, 7, 7, {mm_pkg::ELEM_W{1'b1}}));
		push_item(mult_item());
	endtask

	// loads just outside the 2x2x2 sizes are dropped
	task automatic test_ignored_loads();
		set_sizes(4'd2, 4'd2, 4'd2);
		fill_missing();
		push_item(make_item(mm_pkg::FUNC_LOAD_A, 2, 0, rand_elem()));
		push_item(make_item(mm_pkg::FUNC_LOAD_A, 0, 2, rand_elem()));
		push_item(make_item(mm_pkg::FUNC_LOAD_B, 2, 0, rand_elem()));
		push_item(make_item(mm_pkg::FUNC_LOAD_B, 0, 2, rand_elem()));
		push_item(make_item(mm_pkg::FUNC_LOAD_A, 7, 7, rand_elem()));
		push_item(mult_item());
	endtask

	// size 0 acts as 1; the spare register index changes nothing
	task automatic test_size_clamp();
		set_sizes(4'd0, 4'd0, 4'd0);
		write_reg(REG_UNUSED, 4'hF);
		cfg_write <= 1'b0;
		@(posedge clk);
		push_item(mult_item());
	endtask

	// largest sizes, the ones above 8 act as 8
	task automatic test_max_size();
		set_sizes(4'd8, 4'd15, 4'd9);
		fill_missing();
		push_item(mult_item());
		repeat (6) push_item(inside_load());
		push_item(mult_item());
	endtask

	// receiver holds off long enough for the block to stall the sender
	task automatic test_backpressure();
		set_sizes(4'd3, 4'd2, 4'd3);
		fill_missing();
		hold_request = HOLD_CYCLES;
		burst_left   = 32;
		push_item(mult_item());
		repeat (6) push_item(inside_load());
		push_item(mult_item());
	endtask

	// well-formed load/multiply sequences with some noise, sizes changing between phases
	task automatic test_random();
		int start;
		start = useful_items;
		while (useful_items - start < RAND_ITEMS) begin
			set_sizes(pick_size(), pick_size(), pick_size());
			repeat ($urandom_range(2, 6)) begin
				repeat ($urandom_range(0, 6)) begin
					case ($urandom_range(0, 7))
						0: push_item(make_item(FUNC_UNUSED, $urandom_range(0, 7),
							$urandom_range(0, 7), $urandom));
						1: push_item(make_item(($urandom_range(0, 1) != 0) ?
							mm_pkg::FUNC_LOAD_B : mm_pkg::FUNC_LOAD_A,
							$urandom_range(0, 7), $urandom_range(0, 7), rand_elem()));
						default: push_item(inside_load());
					endcase
				end
				fill_missing();
				push_item(mult_item());
			end
		end
	endtask

	// ---------------------------------------------------------------- run

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_item   = '0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_sizes();
		test_unused_func();
		test_ignored_loads();
		test_size_clamp();
		test_max_size();
		test_backpressure();
		test_random();

		// drain what is still owed, bounded
		in_valid <= 1'b0;
		for (int waited = 0; c_due.size() != 0 && waited < DRAIN_LIMIT; waited++)
			@(posedge clk);
		if (c_due.size() != 0)
			note_error($sformatf("%0d result items never arrived", c_due.size()));
		repeat (END_SETTLE) @(posedge clk);

		if (error_count == 0) begin
			$display("** matrix_multiply: PASSED **");
		end else begin
			$display("** matrix_multiply: FAILED **");
		end
		$finish;
	end

endmodule

/* matrix_multiply.f */
rtl/mm_pkg.sv
rtl/mm_ram.sv
rtl/mm_seq.sv
rtl/mm_mac.sv
rtl/matrix_multiply.sv
bench/tb_matrix_multiply.sv
